// ----- rtl/sabavg_pkg.sv -----
`timescale 1ns / 1ps

package sabavg_pkg;

  // Angles are degrees in Q8 on the result side and Q16 inside the rotator.
  localparam int MEAN_W     = 17;
  localparam int ACC_OUT_W  = 11;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_W      = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int ITERS  = 16;
  localparam int ITER_W = 4;
  localparam int ATAN_W = 22;
  localparam int Z_W    = 27;

  localparam logic signed [MEAN_W-1:0] ANGLE_POS = 17'sd46080;
  localparam logic signed [MEAN_W-1:0] ANGLE_NEG = -17'sd46080;
  localparam logic signed [MEAN_W-1:0] ANGLE_90  = 17'sd23040;
  localparam logic signed [Z_W-1:0]    Z_HALF    = 27'sd11796480;
  localparam logic signed [Z_W-1:0]    Z_ROUND   = 27'sd128;

  localparam logic [CFG_W-1:0] MIN_ANGLE_RST = 8'd20;
  localparam logic [CFG_W-1:0] MAX_ANGLE_RST = 8'd65;

  // Register indexes, taken from the word address.
  localparam logic REG_MIN_ANGLE = 1'b0;
  localparam logic REG_MAX_ANGLE = 1'b1;

  // atan(2^-i) in degrees, Q16.
  localparam logic [ATAN_W-1:0] ATAN_Q16 [ITERS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

endpackage

// ----- rtl/segment_angle_band_average.sv -----
`timescale 1ns / 1ps

// Segment angle band average. Each input request carries one line segment; the block
// finds its angle atan2(dy, dx) in degrees Q8 with a 16-step vectoring CORDIC that
// performs one rotation per cycle, keeps the segment when min_angle_deg < |angle| <
// max_angle_deg, and accumulates accepted angles and their count. A segment occupies
// the block, which takes no new request until it is through with it, also when dx or dy
// is zero (no rotation is run then) or the frame is already at capacity. The request
// flagged with tlast also runs a bit-serial restoring divider over the running sum,
// one quotient bit per cycle (skipped when no segment was accepted), and then emits
// the truncated mean. The result waits in an output register, so the next segment is
// taken while the result is still pending; a further tlast request stalls until that
// register has been taken. Bounds are to be written through the APB port only while
// the block is idle; the block itself does not enforce this. min_angle_deg is at 0x0
// and max_angle_deg at 0x4.
module segment_angle_band_average #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 10
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // x_start, y_start, x_end, y_end (COORD_BITS each, from bit 0 up), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // mean_angle [16:0], accepted_total [27:17], overflow [28], zero padded
  output logic [sabavg_pkg::OUT_DATA_W-1:0] out_tdata,
  // mean_valid
  output logic out_tuser,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [sabavg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sabavg_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sabavg_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic cfg_pready
);
  import sabavg_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int CW      = COORD_BITS + 19;
  localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SUM_W   = COUNT_W + MEAN_W;
  localparam int DC_W    = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROT, ST_ROUND, ST_TEST, ST_FIN, ST_DIV, ST_EMIT
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] min_angle_r, max_angle_r;

  logic signed [CW-1:0]     x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic [ITER_W-1:0]        iter_r;
  logic signed [MEAN_W-1:0] angle_r;
  logic                     last_r;

  logic signed [SUM_W-1:0] sum_r;
  logic [COUNT_W-1:0]      acc_cnt_r;
  logic [COUNT_W-1:0]      seg_cnt_r;
  logic                    ovf_r;

  logic [SUM_W-1:0]   q_r;
  logic [COUNT_W-1:0] rem_r;
  logic [DC_W-1:0]    div_cnt_r;
  logic               sign_r;

  logic                    out_valid_r;
  logic [MEAN_W-1:0]       out_mean_r;
  logic [ACC_OUT_W-1:0]    out_total_r;
  logic                    out_ovf_r;
  logic                    out_flag_r;

  // Input unpacking and fold into the right half plane.
  logic [C-1:0]     xs_in, ys_in, xe_in, ye_in;
  logic signed [C:0] dx_in, dy_in, fold_x, fold_y;
  logic signed [Z_W-1:0] base_z;

  assign xs_in = in_tdata[C-1:0];
  assign ys_in = in_tdata[2*C-1:C];
  assign xe_in = in_tdata[3*C-1:2*C];
  assign ye_in = in_tdata[4*C-1:3*C];
  assign dx_in = $signed({1'b0, xe_in}) - $signed({1'b0, xs_in});
  assign dy_in = $signed({1'b0, ye_in}) - $signed({1'b0, ys_in});
  assign fold_x = dx_in[C] ? -dx_in : dx_in;
  assign fold_y = dx_in[C] ? -dy_in : dy_in;

  always_comb begin
    base_z = '0;
    if (dx_in[C]) begin
      base_z = dy_in[C] ? -Z_HALF : Z_HALF;
    end
  end

  // One CORDIC rotation.
  logic signed [CW-1:0]  xs_sh, ys_sh;
  logic signed [Z_W-1:0] atan_z;
  logic                  y_pos;
  logic signed [CW-1:0]  x_nxt, y_nxt;
  logic signed [Z_W-1:0] z_nxt;

  assign xs_sh  = x_r >>> iter_r;
  assign ys_sh  = y_r >>> iter_r;
  assign atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q16[iter_r]});
  assign y_pos  = !y_r[CW-1] && (y_r != '0);
  assign x_nxt  = y_pos ? x_r + ys_sh : x_r - ys_sh;
  assign y_nxt  = y_pos ? y_r - xs_sh : y_r + xs_sh;
  assign z_nxt  = y_pos ? z_r + atan_z : z_r - atan_z;

  // Round Q16 to Q8 (floor of z + 1/2 LSB) and clamp to +/-180 degrees.
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [Z_W-9:0]   z_q8;
  logic signed [MEAN_W-1:0] angle_rnd;

  assign z_rnd = z_r + Z_ROUND;
  assign z_q8  = z_rnd[Z_W-1:8];

  always_comb begin
    if (z_q8 > ANGLE_POS) begin
      angle_rnd = ANGLE_POS;
    end else if (z_q8 < ANGLE_NEG) begin
      angle_rnd = ANGLE_NEG;
    end else begin
      angle_rnd = z_q8[MEAN_W-1:0];
    end
  end

  // Band test.
  logic [MEAN_W-1:0] mag;
  logic [MEAN_W-1:0] lo_bound, hi_bound;
  logic              in_band;

  assign mag      = angle_r[MEAN_W-1] ? MEAN_W'(-angle_r) : MEAN_W'(angle_r);
  assign lo_bound = {1'b0, min_angle_r, 8'h00};
  assign hi_bound = {1'b0, max_angle_r, 8'h00};
  assign in_band  = (mag > lo_bound) && (mag < hi_bound);

  // Divider step and sum magnitude.
  logic [SUM_W-1:0]   sum_mag;
  logic [COUNT_W:0]   rem_sh, rem_diff;
  logic               rem_ge;
  logic [SUM_W-1:0]   mean_full;

  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rem_sh    = {rem_r, q_r[SUM_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, acc_cnt_r};
  assign rem_diff  = rem_sh - {1'b0, acc_cnt_r};
  assign mean_full = sign_r ? -q_r : q_r;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_angle_r <= MIN_ANGLE_RST;
      max_angle_r <= MAX_ANGLE_RST;
      sum_r       <= '0;
      acc_cnt_r   <= '0;
      seg_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_MIN_ANGLE: min_angle_r <= cfg_pwdata[CFG_W-1:0];
          REG_MAX_ANGLE: max_angle_r <= cfg_pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      // The emit state reloads the output register itself.
      if (out_valid_r && out_tready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            last_r <= in_tlast;
            if (seg_cnt_r == COUNT_W'(MAX_SEGMENTS)) begin
              ovf_r   <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              seg_cnt_r <= seg_cnt_r + 1'b1;
              if (dy_in == '0) begin
                angle_r <= dx_in[C] ? ANGLE_POS : '0;
                state_r <= ST_TEST;
              end else if (dx_in == '0) begin
                angle_r <= dy_in[C] ? -ANGLE_90 : ANGLE_90;
                state_r <= ST_TEST;
              end else begin
                x_r     <= {{(CW-C-17){fold_x[C]}}, fold_x, 16'h0000};
                y_r     <= {{(CW-C-17){fold_y[C]}}, fold_y, 16'h0000};
                z_r     <= base_z;
                iter_r  <= '0;
                state_r <= ST_ROT;
              end
            end
          end
        end

        ST_ROT: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_W'(ITERS - 1)) begin
            state_r <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          angle_r <= angle_rnd;
          state_r <= ST_TEST;
        end

        ST_TEST: begin
          if (in_band) begin
            sum_r     <= sum_r + {{(SUM_W-MEAN_W){angle_r[MEAN_W-1]}}, angle_r};
            acc_cnt_r <= acc_cnt_r + 1'b1;
          end
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (acc_cnt_r == '0) begin
            q_r     <= '0;
            sign_r  <= 1'b0;
            state_r <= ST_EMIT;
          end else begin
            q_r       <= sum_mag;
            sign_r    <= sum_r[SUM_W-1];
            rem_r     <= '0;
            div_cnt_r <= DC_W'(SUM_W - 1);
            state_r   <= ST_DIV;
          end
        end

        ST_DIV: begin
          // Restoring division: one quotient bit enters at the bottom each cycle.
          rem_r     <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
          q_r       <= {q_r[SUM_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_full[MEAN_W-1:0];
            out_total_r <= ACC_OUT_W'(acc_cnt_r);
            out_ovf_r   <= ovf_r;
            out_flag_r  <= acc_cnt_r != '0;
            sum_r       <= '0;
            acc_cnt_r   <= '0;
            seg_cnt_r   <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-MEAN_W-ACC_OUT_W-1){1'b0}},
                       out_ovf_r, out_total_r, out_mean_r};
  assign out_tuser  = out_flag_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_ANGLE)
                      ? {{(CFG_DATA_W-CFG_W){1'b0}}, max_angle_r}
                      : {{(CFG_DATA_W-CFG_W){1'b0}}, min_angle_r};

endmodule
